### sv/gpps_pkg.sv
// Shared types and constants for the gapped pair pattern search.
// No dependencies; imported by every module and the req/csr interfaces.
package gpps_pkg;

   localparam int PAT_A_LEN = 2;
   localparam int PAT_B_LEN = 2;
   localparam int MAX_GAP   = 10;
   localparam int WIN_LEN   = PAT_A_LEN + MAX_GAP - 1 + PAT_B_LEN;
   localparam int FILL_W    = $clog2(WIN_LEN + 1);
   localparam int PAT_W     = 4;
   localparam int CSR_IDX_W = 2;

   typedef logic [1:0]                    sym_type;
   typedef logic [PAT_W-1:0]              pat_type;
   typedef logic [FILL_W-1:0]             fill_type;
   typedef logic [CSR_IDX_W-1:0]          csr_idx_type;
   typedef logic [WIN_LEN-1:0][1:0]       window_type;

   localparam csr_idx_type CSR_PATTERN_A = csr_idx_type'(0);
   localparam csr_idx_type CSR_PATTERN_B = csr_idx_type'(1);

endpackage

### sv/gpps_ifs.sv
// Valid/ready channel interfaces: symbol input, result output, register writes.
// Depends on gpps_pkg.
interface gpps_req_if;
   import gpps_pkg::*;
   logic    valid;
   logic    ready;
   sym_type symbol;
   logic    last_symbol;
   modport source (output valid, symbol, last_symbol, input ready);
   modport sink   (input valid, symbol, last_symbol, output ready);
endinterface

interface gpps_rsp_if;
   logic valid;
   logic ready;
   logic found;
   modport source (output valid, found, input ready);
   modport sink   (input valid, found, output ready);
endinterface

interface gpps_csr_if;
   import gpps_pkg::*;
   logic        valid;
   logic        ready;
   csr_idx_type index;
   pat_type     data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

### sv/gpps_match.sv
// Gap comparator: tests every gap placement of pattern A then pattern B in parallel.
// Depends on gpps_pkg.
module gpps_match (
   input  gpps_pkg::window_type window,
   input  gpps_pkg::fill_type   fill,
   input  gpps_pkg::pat_type    pattern_a,
   input  gpps_pkg::pat_type    pattern_b,
   output logic                 hit
);
   import gpps_pkg::*;

   logic [MAX_GAP-1:0] gap_hit;

   always_comb begin
      for (int g = 0; g < MAX_GAP; g++) begin
         gap_hit[g] = (fill >= FILL_W'(PAT_A_LEN + g + PAT_B_LEN));
         for (int j = 0; j < PAT_A_LEN; j++) begin
            if (window[PAT_A_LEN + g + PAT_B_LEN - 1 - j] != pattern_a[2*j +: 2]) begin
               gap_hit[g] = 1'b0;
            end
         end
         for (int j = 0; j < PAT_B_LEN; j++) begin
            if (window[PAT_B_LEN - 1 - j] != pattern_b[2*j +: 2]) begin
               gap_hit[g] = 1'b0;
            end
         end
      end
   end

   assign hit = |gap_hit;

endmodule

### sv/gapped_pair_pattern_search.sv
// Top level of the gapped pair pattern search.
// Depends on gpps_pkg, the channel interfaces and gpps_match.
//
// Usage:
//  req carries one 2-bit symbol per transfer, last_symbol marking the end
//  of a sequence. rsp carries one transfer per sequence: found is 1 when
//  pattern A was followed, after a gap of 0 to MAX_GAP-1 symbols, by
//  pattern B anywhere inside that sequence. csr writes pattern_a (index 0)
//  and pattern_b (index 1); other indexes are dropped. csr is always ready;
//  write it only while no sequence is in flight.
//  Throughput: one symbol per cycle unless a final symbol is held back. A
//  symbol goes into the input register on its transfer and is then compared
//  against the window; the result of a last symbol lands in the output
//  register, which drives rsp.valid. The single compare stage lies between
//  the two registers. Reset clears both patterns, the fill count, the match
//  flag and both valid flags. While rsp is stalled, non-final symbols keep
//  flowing; a final symbol waits in the input register and req.ready drops
//  behind it.
module gapped_pair_pattern_search (
   input  logic       clock,
   input  logic       reset,
   gpps_req_if.sink   req,
   gpps_rsp_if.source rsp,
   gpps_csr_if.sink   csr
);
   import gpps_pkg::*;

   logic       in_valid_ff;
   sym_type    in_sym_ff;
   logic       in_last_ff;
   window_type window_ff;
   fill_type   fill_ff;
   logic       seen_ff;
   logic       rsp_valid_ff;
   logic       found_ff;
   pat_type    pattern_a_ff;
   pat_type    pattern_b_ff;

   window_type window_in;
   fill_type   fill_in;
   logic       seen_in;
   logic       hit;
   logic       out_free;
   logic       process;
   logic       req_xfer;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign process   = in_valid_ff && (!in_last_ff || out_free);
   assign req.ready = !in_valid_ff || process;
   assign req_xfer  = req.valid && req.ready;
   assign csr.ready = 1'b1;

   assign window_in = {window_ff[WIN_LEN-2:0], in_sym_ff};
   assign fill_in   = (fill_ff == FILL_W'(WIN_LEN)) ? fill_ff : fill_ff + FILL_W'(1);
   assign seen_in   = seen_ff || hit;

   gpps_match u_match (
      .window    (window_in),
      .fill      (fill_in),
      .pattern_a (pattern_a_ff),
      .pattern_b (pattern_b_ff),
      .hit       (hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         fill_ff      <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pattern_a_ff <= '0;
         pattern_b_ff <= '0;
      end else begin
         if (csr.valid) begin
            unique case (csr.index)
               CSR_PATTERN_A: pattern_a_ff <= csr.data;
               CSR_PATTERN_B: pattern_b_ff <= csr.data;
               default: ;
            endcase
         end
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (process) begin
            if (in_last_ff) begin
               fill_ff <= '0;
               seen_ff <= 1'b0;
            end else begin
               fill_ff <= fill_in;
               seen_ff <= seen_in;
            end
         end
         if (process && in_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_sym_ff  <= req.symbol;
         in_last_ff <= req.last_symbol;
      end
      if (process) begin
         window_ff <= window_in;
      end
      if (process && in_last_ff) begin
         found_ff <= seen_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.found = found_ff;

endmodule

### sv/gpps_checker.sv
// Port-level checks for the gapped pair pattern search, bound to the top level.
// Depends on gpps_pkg and gapped_pair_pattern_search.
module gpps_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_last_symbol,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_found
);
   import gpps_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_found_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_found))
      else $error("found changed while stalled");

   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last_symbol, 2))
      else $error("result without a final symbol transfer two cycles earlier");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind gapped_pair_pattern_search gpps_checker u_gpps_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req.valid),
   .req_ready       (req.ready),
   .req_last_symbol (req.last_symbol),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_found       (rsp.found)
);
